// ===== rtl/sbi_pkg.sv =====
// Shared widths, payload types and latency figures for the sphere/box intersection unit.
package sbi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int MAG_WIDTH   = COORD_WIDTH;
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH   = SQ_WIDTH + 2;
    localparam int ROOT_IN_W   = 2 * RAD_WIDTH;
    localparam int NRM_WIDTH   = 16;
    localparam int NRM_SHIFT   = 14;
    localparam int QUO_BITS    = NRM_SHIFT + 1;
    localparam int NUM_WIDTH   = RAD_WIDTH + QUO_BITS;
    localparam int FRONT_STAGES = 4;
    localparam int LATENCY     = FRONT_STAGES + RAD_WIDTH + QUO_BITS + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic        [RAD_WIDTH-1:0]   sphere_radius;
        logic signed [COORD_WIDTH-1:0] box_min_x;
        logic signed [COORD_WIDTH-1:0] box_min_y;
        logic signed [COORD_WIDTH-1:0] box_min_z;
        logic signed [COORD_WIDTH-1:0] box_max_x;
        logic signed [COORD_WIDTH-1:0] box_max_y;
        logic signed [COORD_WIDTH-1:0] box_max_z;
    } sbi_in_t;

    typedef struct packed {
        logic                        hit;
        logic        [RAD_WIDTH-1:0] depth;
        logic signed [NRM_WIDTH-1:0] normal_x;
        logic signed [NRM_WIDTH-1:0] normal_y;
        logic signed [NRM_WIDTH-1:0] normal_z;
        logic                        center_inside;
    } sbi_out_t;

    typedef struct packed {
        logic                      hit;
        logic [RAD_WIDTH-1:0]      rad;
        logic [2:0]                neg;
        logic [2:0][RAD_WIDTH-1:0] mag;
    } sbi_side_t;

endpackage

// ===== rtl/sbi_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
module sbi_sqrt_pipe
    import sbi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [ROOT_IN_W-1:0] radicand,
    input  sbi_side_t            in_side,
    output logic                 out_valid,
    output logic [RAD_WIDTH-1:0] root,
    output sbi_side_t            out_side
);

    logic                 valid_reg [RAD_WIDTH];
    logic [RAD_WIDTH+1:0] rem_reg   [RAD_WIDTH];
    logic [RAD_WIDTH-1:0] root_reg  [RAD_WIDTH];
    logic [ROOT_IN_W-1:0] rad_reg   [RAD_WIDTH];
    sbi_side_t            side_reg  [RAD_WIDTH];

    for (genvar j = 0; j < RAD_WIDTH; j++) begin : g_stage
        logic                 valid_prev;
        logic [RAD_WIDTH+1:0] rem_prev;
        logic [RAD_WIDTH-1:0] root_prev;
        logic [ROOT_IN_W-1:0] rad_prev;
        sbi_side_t            side_prev;
        logic [RAD_WIDTH+1:0] rem_in;
        logic [RAD_WIDTH+1:0] trial;
        logic                 ge;

        if (j == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = radicand;
            assign side_prev  = in_side;
        end else begin : g_next
            assign valid_prev = valid_reg[j-1];
            assign rem_prev   = rem_reg[j-1];
            assign root_prev  = root_reg[j-1];
            assign rad_prev   = rad_reg[j-1];
            assign side_prev  = side_reg[j-1];
        end

        assign rem_in = {rem_prev[RAD_WIDTH-1:0], rad_prev[ROOT_IN_W-1 -: 2]};
        assign trial  = {root_prev, 2'b01};
        assign ge     = (rem_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? (rem_in - trial) : rem_in;
            root_reg[j] <= {root_prev[RAD_WIDTH-2:0], ge};
            rad_reg[j]  <= rad_prev << 2;
            side_reg[j] <= side_prev;
        end
    end

    assign out_valid = valid_reg[RAD_WIDTH-1];
    assign root      = root_reg[RAD_WIDTH-1];
    assign out_side  = side_reg[RAD_WIDTH-1];

endmodule

// ===== rtl/sbi_div_pipe.sv =====
// Pipelined three-lane normal divider and final result formatting.
module sbi_div_pipe
    import sbi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RAD_WIDTH-1:0] dist_in,
    input  sbi_side_t            in_side,
    output logic                 out_valid,
    output sbi_out_t             out_word
);

    logic                            valid_reg [QUO_BITS];
    logic [2:0][NUM_WIDTH-1:0]       rem_reg   [QUO_BITS];
    logic [2:0][QUO_BITS-1:0]        quo_reg   [QUO_BITS];
    logic [RAD_WIDTH-1:0]            dist_reg  [QUO_BITS];
    sbi_side_t                       side_reg  [QUO_BITS];

    logic     out_valid_reg;
    sbi_out_t out_reg;
    sbi_out_t out_next;

    for (genvar t = 0; t < QUO_BITS; t++) begin : g_stage
        localparam int BIT = QUO_BITS - 1 - t;
        logic                      valid_prev;
        logic [2:0][NUM_WIDTH-1:0] rem_prev;
        logic [2:0][QUO_BITS-1:0]  quo_prev;
        logic [RAD_WIDTH-1:0]      dist_prev;
        sbi_side_t                 side_prev;
        logic [NUM_WIDTH-1:0]      dsh;

        if (t == 0) begin : g_first
            for (genvar a = 0; a < 3; a++) begin : g_num
                assign rem_prev[a] = {1'b0, in_side.mag[a], {NRM_SHIFT{1'b0}}}
                                   + NUM_WIDTH'(dist_in >> 1);
            end
            assign valid_prev = in_valid;
            assign quo_prev   = '0;
            assign dist_prev  = dist_in;
            assign side_prev  = in_side;
        end else begin : g_next
            assign valid_prev = valid_reg[t-1];
            assign rem_prev   = rem_reg[t-1];
            assign quo_prev   = quo_reg[t-1];
            assign dist_prev  = dist_reg[t-1];
            assign side_prev  = side_reg[t-1];
        end

        assign dsh = NUM_WIDTH'(dist_prev) << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[t] <= 1'b0;
            end
            else
            begin
                valid_reg[t] <= valid_prev;
            end
        end

        for (genvar a = 0; a < 3; a++) begin : g_lane
            logic ge;
            assign ge = (rem_prev[a] >= dsh);
            always_ff @(posedge clk)
            begin
                rem_reg[t][a] <= ge ? (rem_prev[a] - dsh) : rem_prev[a];
                quo_reg[t][a] <= quo_prev[a] | (QUO_BITS'(ge) << BIT);
            end
        end

        always_ff @(posedge clk)
        begin
            dist_reg[t] <= dist_prev;
            side_reg[t] <= side_prev;
        end
    end

    always_comb
    begin
        logic                         zero_dist;
        logic [2:0][NRM_WIDTH-1:0]    nrm;
        sbi_side_t                    sd;
        sd        = side_reg[QUO_BITS-1];
        zero_dist = (dist_reg[QUO_BITS-1] == '0);
        for (int a = 0; a < 3; a++)
        begin
            nrm[a] = NRM_WIDTH'(quo_reg[QUO_BITS-1][a]);
            if (sd.neg[a])
            begin
                nrm[a] = -nrm[a];
            end
            if (zero_dist || !sd.hit)
            begin
                nrm[a] = '0;
            end
        end
        out_next.hit           = sd.hit;
        out_next.depth         = sd.hit ? (sd.rad - dist_reg[QUO_BITS-1]) : '0;
        out_next.normal_x      = nrm[0];
        out_next.normal_y      = nrm[1];
        out_next.normal_z      = nrm[2];
        out_next.center_inside = sd.hit && zero_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[QUO_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== rtl/sphere_box_intersection_unit.sv =====
// Top level of the sphere against axis-aligned box intersection unit.
// Usage: drive one sphere/box pair on pair and raise start; the word is
// taken at every rising edge where start is high and busy is low.
// Busy stays low, so a new pair may enter on every cycle.
// The result word appears on result with done high for exactly one cycle,
// after the front end, the square root pipeline, the normal divider and the
// output register, in the same order the pairs entered.
// Throughput is one pair per cycle; the square root pipeline has one stage
// per root bit, and the normal divider has one stage per quotient bit, with
// three lanes in parallel.
// The front end clamps, squares, sums and compares in four stages.
// Reset clears every valid bit, so no result appears until a pair enters.
// The receiver cannot stall; every result must be taken when done is high.
module sphere_box_intersection_unit
    import sbi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sbi_in_t  pair,
    output logic     done,
    output sbi_out_t result
);

    logic signed [COORD_WIDTH-1:0] c_in  [3];
    logic signed [COORD_WIDTH-1:0] lo_in [3];
    logic signed [COORD_WIDTH-1:0] hi_in [3];

    logic                      s1_valid_reg;
    logic [2:0][MAG_WIDTH-1:0] s1_mag_reg;
    logic [2:0]                s1_neg_reg;
    logic [RAD_WIDTH-1:0]      s1_rad_reg;
    logic [2:0][MAG_WIDTH-1:0] s1_mag_next;
    logic [2:0]                s1_neg_next;

    logic                      s2_valid_reg;
    logic [2:0][SQ_WIDTH-1:0]  s2_sq_reg;
    logic [ROOT_IN_W-1:0]      s2_r2_reg;
    sbi_side_t                 s2_side_reg;

    logic                      s3_valid_reg;
    logic [SUM_WIDTH-1:0]      s3_sum_reg;
    logic [ROOT_IN_W-1:0]      s3_r2_reg;
    sbi_side_t                 s3_side_reg;

    logic                      s4_valid_reg;
    logic [ROOT_IN_W-1:0]      s4_rad_reg;
    sbi_side_t                 s4_side_reg;
    sbi_side_t                 s4_side_next;

    logic                      sq_valid;
    logic [RAD_WIDTH-1:0]      sq_root;
    sbi_side_t                 sq_side;

    assign busy = 1'b0;

    assign c_in[0]  = pair.center_x;
    assign c_in[1]  = pair.center_y;
    assign c_in[2]  = pair.center_z;
    assign lo_in[0] = pair.box_min_x;
    assign lo_in[1] = pair.box_min_y;
    assign lo_in[2] = pair.box_min_z;
    assign hi_in[0] = pair.box_max_x;
    assign hi_in[1] = pair.box_max_y;
    assign hi_in[2] = pair.box_max_z;

    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] cl;
        logic signed [COORD_WIDTH:0]   d;
        logic        [COORD_WIDTH:0]   nd;
        for (int a = 0; a < 3; a++)
        begin
            priority if (c_in[a] < lo_in[a])
            begin
                cl = lo_in[a];
            end
            else if (c_in[a] > hi_in[a])
            begin
                cl = hi_in[a];
            end
            else
            begin
                cl = c_in[a];
            end
            d  = {c_in[a][COORD_WIDTH-1], c_in[a]} - {cl[COORD_WIDTH-1], cl};
            nd = -d;
            s1_neg_next[a] = d[COORD_WIDTH];
            s1_mag_next[a] = d[COORD_WIDTH] ? nd[MAG_WIDTH-1:0] : d[MAG_WIDTH-1:0];
        end
    end

    always_comb
    begin
        s4_side_next     = s3_side_reg;
        s4_side_next.hit = (s3_sum_reg <= SUM_WIDTH'(s3_r2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg <= s1_mag_next;
        s1_neg_reg <= s1_neg_next;
        s1_rad_reg <= pair.sphere_radius;

        for (int a = 0; a < 3; a++)
        begin
            s2_sq_reg[a]       <= s1_mag_reg[a] * s1_mag_reg[a];
            s2_side_reg.mag[a] <= s1_mag_reg[a][RAD_WIDTH-1:0];
        end
        s2_r2_reg        <= s1_rad_reg * s1_rad_reg;
        s2_side_reg.neg  <= s1_neg_reg;
        s2_side_reg.rad  <= s1_rad_reg;
        s2_side_reg.hit  <= 1'b0;

        s3_sum_reg  <= SUM_WIDTH'(s2_sq_reg[0]) + SUM_WIDTH'(s2_sq_reg[1])
                     + SUM_WIDTH'(s2_sq_reg[2]);
        s3_r2_reg   <= s2_r2_reg;
        s3_side_reg <= s2_side_reg;

        s4_rad_reg  <= s3_sum_reg[ROOT_IN_W-1:0];
        s4_side_reg <= s4_side_next;
    end

    sbi_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .radicand  (s4_rad_reg),
        .in_side   (s4_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    sbi_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .dist_in   (sq_root),
        .in_side   (sq_side),
        .out_valid (done),
        .out_word  (result)
    );

endmodule

// ===== rtl/sbi_checker.sv =====
// Port-level assertions for the intersection unit and their bind statement.
module sbi_checker
    import sbi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input sbi_out_t result
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the pipeline never stalls");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result word without a pair taken at the expected latency");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.depth == '0 && result.normal_x == '0
            && result.normal_y == '0 && result.normal_z == '0 && !result.center_inside))
        else $error("miss word carries nonzero fields");

    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.center_inside) |-> (result.hit && result.normal_x == '0
            && result.normal_y == '0 && result.normal_z == '0))
        else $error("inside word with a normal or without a hit");

    a_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit && !result.center_inside) |->
            (result.normal_x != '0 || result.normal_y != '0 || result.normal_z != '0))
        else $error("surface hit with a zero normal");

endmodule

bind sphere_box_intersection_unit sbi_checker u_sbi_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== dv/sphere_box_intersection_unit_test.sv =====
// Self-checking testbench for the sphere against axis-aligned box intersection unit.
module sphere_box_intersection_unit_test;
    import sbi_pkg::*;

    class contact_scoreboard;
        sbi_out_t expected_q[$];
        int errors;

        function automatic sbi_out_t compute_contact(sbi_in_t p);
            logic signed [COORD_WIDTH:0] d[3];
            logic signed [COORD_WIDTH-1:0] c, lo, hi, cl;
            logic [COORD_WIDTH:0] m[3];
            logic [SUM_WIDTH-1:0] s, cand_sq;
            logic [ROOT_IN_W-1:0] rad_sq;
            logic [63:0] droot, cand, q;
            sbi_out_t r;
            for (int a = 0; a < 3; a++)
            begin
                c  = (a == 0) ? p.center_x : (a == 1) ? p.center_y : p.center_z;
                lo = (a == 0) ? p.box_min_x : (a == 1) ? p.box_min_y : p.box_min_z;
                hi = (a == 0) ? p.box_max_x : (a == 1) ? p.box_max_y : p.box_max_z;
                if (c < lo) cl = lo;
                else if (c > hi) cl = hi;
                else cl = c;
                d[a] = $signed({c[COORD_WIDTH-1], c}) - $signed({cl[COORD_WIDTH-1], cl});
                m[a] = d[a][COORD_WIDTH] ? -d[a] : d[a];
            end
            s = '0;
            for (int a = 0; a < 3; a++)
                s = s + m[a] * m[a];
            rad_sq = p.sphere_radius * p.sphere_radius;
            r = '0;
            if (s <= rad_sq)
            begin
                droot = '0;
                for (int b = 31; b >= 0; b--)
                begin
                    cand = droot | (64'd1 << b);
                    cand_sq = cand * cand;
                    if (cand_sq <= s) droot = cand;
                end
                r.hit = 1'b1;
                r.depth = p.sphere_radius - droot[RAD_WIDTH-1:0];
                if (droot == 0)
                    r.center_inside = 1'b1;
                else
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        q = (m[a] * 64'd16384 + droot / 2) / droot;
                        if (d[a][COORD_WIDTH]) q = -q;
                        if (a == 0) r.normal_x = q[15:0];
                        else if (a == 1) r.normal_y = q[15:0];
                        else r.normal_z = q[15:0];
                    end
                end
            end
            return r;
        endfunction

        function void note_pair(sbi_in_t p);
            expected_q.push_back(compute_contact(p));
        endfunction

        task automatic report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task automatic check_word(sbi_out_t got);
            sbi_out_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected word", 64'(got.hit), 64'd0);
                return;
            end
            e = expected_q.pop_front();
            if (got.hit !== e.hit) report("hit", 64'(got.hit), 64'(e.hit));
            if (got.depth !== e.depth) report("depth", 64'(got.depth), 64'(e.depth));
            if (got.normal_x !== e.normal_x)
                report("normal_x", 64'(got.normal_x), 64'(e.normal_x));
            if (got.normal_y !== e.normal_y)
                report("normal_y", 64'(got.normal_y), 64'(e.normal_y));
            if (got.normal_z !== e.normal_z)
                report("normal_z", 64'(got.normal_z), 64'(e.normal_z));
            if (got.center_inside !== e.center_inside)
                report("center_inside", 64'(got.center_inside), 64'(e.center_inside));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    sbi_in_t pair;
    sbi_out_t result;
    contact_scoreboard board;

    sphere_box_intersection_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pair(pair),
        .done(done),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_word(result);
    end

    function automatic logic [31:0] rand_coord(int scale);
        logic [31:0] v;
        v = $urandom();
        case (scale)
            0: v = $signed(v) >>> 12;
            1: v = $signed(v) >>> 20;
            default: ;
        endcase
        return v;
    endfunction

    function automatic sbi_in_t random_pair();
        sbi_in_t p;
        logic [31:0] lo, hi, t;
        int scale;
        scale = $urandom_range(0, 3);
        p.center_x = rand_coord(scale);
        p.center_y = rand_coord(scale);
        p.center_z = rand_coord(scale);
        for (int a = 0; a < 3; a++)
        begin
            lo = rand_coord(scale);
            hi = rand_coord(scale);
            if ($urandom_range(0, 7) != 0 && $signed(lo) > $signed(hi))
            begin
                t = lo;
                lo = hi;
                hi = t;
            end
            if (a == 0) begin p.box_min_x = lo; p.box_max_x = hi; end
            else if (a == 1) begin p.box_min_y = lo; p.box_max_y = hi; end
            else begin p.box_min_z = lo; p.box_max_z = hi; end
        end
        case ($urandom_range(0, 4))
            0: p.sphere_radius = 31'($urandom());
            1: p.sphere_radius = '0;
            default: p.sphere_radius = 31'(rand_coord(scale));
        endcase
        if ($urandom_range(0, 3) == 0)
            p.sphere_radius = p.sphere_radius | 31'($urandom() >> 1);
        return p;
    endfunction

    task automatic send_pair(sbi_in_t p);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            @(posedge clk);
            start <= 1'b0;
        end
        @(posedge clk);
        start <= 1'b1;
        pair <= p;
        do @(posedge clk); while (busy);
        board.note_pair(p);
        start <= 1'b0;
    endtask

    task automatic send_pair_run(sbi_in_t p);
        start <= 1'b1;
        pair <= p;
        do @(posedge clk); while (busy);
        board.note_pair(p);
    endtask

    task automatic drain();
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic sbi_in_t make_pair(logic [31:0] c, logic [30:0] r,
                                          logic [31:0] lo, logic [31:0] hi);
        sbi_in_t p;
        p.center_x = c; p.center_y = c; p.center_z = c;
        p.sphere_radius = r;
        p.box_min_x = lo; p.box_min_y = lo; p.box_min_z = lo;
        p.box_max_x = hi; p.box_max_y = hi; p.box_max_z = hi;
        return p;
    endfunction

    initial
    begin
        sbi_in_t p;
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        pair = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_pair(make_pair(32'h0, 31'h0, 32'h0, 32'h0));
        send_pair(make_pair(32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_pair(make_pair(32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
        send_pair(make_pair(32'h0001_0000, 31'h0, 32'hffff_0000, 32'h0002_0000));
        send_pair(make_pair(32'h0003_0000, 31'h0, 32'h0, 32'h0002_0000));
        send_pair(make_pair(32'h0003_0000, 31'h7fff_ffff, 32'h0, 32'h0002_0000));
        send_pair(make_pair(32'h0001_0000, 31'h0003_0000, 32'h0002_0000, 32'h0));
        send_pair(make_pair(32'h0003_0000, 31'h0004_0000, 32'h0002_0000, 32'h0));
        send_pair(make_pair(32'hffff_0000, 31'h0004_0000, 32'h0002_0000, 32'h0));
        send_pair(make_pair(32'h0002_0000, 31'h0, 32'h0, 32'h0002_0000));
        p = make_pair(32'h0, 31'h0001_0000, 32'h0, 32'h0);
        p.center_x = 32'h0001_0000;
        send_pair(p);
        p.center_x = 32'hffff_0000;
        send_pair(p);
        p.sphere_radius = 31'h0000_ffff;
        send_pair(p);
        p = make_pair(32'h0, 31'h7fff_ffff, 32'h0, 32'h0);
        p.center_x = 32'h8000_0000;
        p.center_y = 32'h7fff_ffff;
        p.box_max_x = 32'h7fff_ffff;
        p.box_min_y = 32'h8000_0000;
        send_pair(p);
        p.center_z = 32'h0000_0003;
        p.sphere_radius = 31'h0000_0005;
        p.center_x = 32'h0; p.center_y = 32'h0000_0004;
        p.box_min_x = 32'h0; p.box_max_x = 32'h0;
        p.box_min_y = 32'h0; p.box_max_y = 32'h0;
        send_pair(p);
        drain();

        for (int i = 0; i < 1450; i++)
        begin
            if (i % 200 == 100)
            begin
                @(posedge clk);
                for (int k = 0; k < 40; k++)
                    send_pair_run(random_pair());
                start <= 1'b0;
            end
            else
                send_pair(random_pair());
            if (i == 900)
                drain();
        end

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
